// ----- hdl/bucketed_hash_set_assert.svh -----
// ----------------------------------------------------------------------------
// Bucketed hash set assertion macros
// Shorthand for clocked concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BUCKETED_HASH_SET_ASSERT_SVH
`define BUCKETED_HASH_SET_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define BHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bhs_pkg.sv -----
// ----------------------------------------------------------------------------
// Bucketed hash set package
// Operation codes and fixed widths shared by the hash set modules.
// ----------------------------------------------------------------------------
package bhs_pkg;

  // Operation codes; any other code is a membership test
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;

  // Key width
  localparam int KEY_W = 31;

  // Result field widths
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 3;

endpackage

// ----- hdl/bhs_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Bucketed hash set remainder unit
// Reduces a key modulo a constant divisor by reciprocal multiplication.
// ----------------------------------------------------------------------------
module bhs_mod_unit import bhs_pkg::*; #(
  parameter int DIVISOR = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [KEY_W-1:0]           key_i,
  output logic                       done_o,
  output logic [$clog2(DIVISOR)-1:0] rem_o
);

  localparam int RW = $clog2(DIVISOR);
  // Shift and reciprocal chosen so the quotient is exact for every key
  localparam int SH = KEY_W + RW;
  localparam int MW = KEY_W + 2;
  localparam int PW = KEY_W + MW;
  localparam int QW = KEY_W - RW + 1;
  localparam longint unsigned RECIP_WIDE =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_WIDE);

  logic              mul_vld_q;
  logic              done_q;
  logic [KEY_W-1:0]  key_q;
  logic [PW-1:0]     prod_q;
  logic [PW-1:0]     prod_d;
  logic [QW-1:0]     quo;
  logic [KEY_W-1:0]  diff;
  logic [RW-1:0]     rem_q;
  logic [RW-1:0]     rem_d;

  // Multiply the key by the scaled reciprocal
  assign prod_d = PW'(key_i) * PW'(RECIP);

  // Take the quotient from the high product bits and subtract it back out
  assign quo   = prod_q[SH +: QW];
  assign diff  = key_q - KEY_W'(quo * DIVISOR);
  assign rem_d = diff[RW-1:0];

  // Two-stage sequence: multiply, then subtract
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      mul_vld_q <= start_i;
      done_q    <= mul_vld_q;
    end
  end

  // Hold the key and product for the subtract stage
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q  <= key_i;
      prod_q <= prod_d;
    end
    if (mul_vld_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/bucketed_hash_set.sv -----
// ----------------------------------------------------------------------------
// Bucketed hash set
// Key set held in fixed buckets of packed slots; insert, delete, membership test.
// ----------------------------------------------------------------------------
//  Channel  Signals                                      Direction
//  in       in_valid_i, in_ready_o, kind_i, key_i        into block
//  out      out_valid_o, out_ready_i, present_o,         out of block
//           rejected_full_o, bucket_index_o, bucket_count_o
//
//  Each transaction is handled in turn: the remainder unit picks the bucket, the
//  fill count is read, the slots are compared one at a time until the key is
//  found or the filled slots run out, and a delete then moves the later entries
//  down one by one. in_ready_o returns as the result is posted.
//  After reset the block clears the fill counts, one bucket a cycle, and holds
//  in_ready_o low until all are cleared. A new transaction is taken while a
//  result waits; a stalled output holds the block before it posts the next.
// ----------------------------------------------------------------------------
module bucketed_hash_set import bhs_pkg::*; #(
  parameter int NUM_BUCKETS      = 10,
  parameter int SLOTS_PER_BUCKET = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [KEY_W-1:0]   key_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               present_o,
  output logic               rejected_full_o,
  output logic [INDEX_W-1:0] bucket_index_o,
  output logic [COUNT_W-1:0] bucket_count_o
);

  localparam int BW    = $clog2(NUM_BUCKETS);
  localparam int FW    = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int DEPTH = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_MOD       = 4'd2;
  localparam logic [3:0] ST_FILL_REQ  = 4'd3;
  localparam logic [3:0] ST_FILL_WAIT = 4'd4;
  localparam logic [3:0] ST_SCAN_REQ  = 4'd5;
  localparam logic [3:0] ST_SCAN_CMP  = 4'd6;
  localparam logic [3:0] ST_DECIDE    = 4'd7;
  localparam logic [3:0] ST_SHIFT_REQ = 4'd8;
  localparam logic [3:0] ST_SHIFT_WR  = 4'd9;
  localparam logic [3:0] ST_DONE      = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [BW-1:0]    clr_q, clr_d;
  logic             started_q;
  logic [1:0]       kind_q, kind_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [BW-1:0]    b_q, b_d;
  logic [AW-1:0]    base_q, base_d;
  logic [FW-1:0]    fill_q, fill_d;
  logic [FW-1:0]    idx_q, idx_d;
  logic [FW-1:0]    idx_inc;
  logic             found_q, found_d;
  logic             rej_q, rej_d;
  logic [FW-1:0]    new_fill_q, new_fill_d;

  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             present_q;
  logic             rejected_q;
  logic [BW+INDEX_W-1:0] index_ext;
  logic [FW+COUNT_W-1:0] count_ext;
  logic [INDEX_W-1:0] index_q;
  logic [COUNT_W-1:0] count_q;

  logic             mod_start;
  logic             mod_done;
  logic [BW-1:0]    mod_rem;

  logic             slot_we;
  logic [AW-1:0]    slot_waddr;
  logic [KEY_W-1:0] slot_wdata;
  logic [AW-1:0]    slot_raddr;
  logic [KEY_W-1:0] slot_rd_q;
  logic [KEY_W-1:0] slot_mem [DEPTH];

  logic             fill_we;
  logic [BW-1:0]    fill_waddr;
  logic [FW-1:0]    fill_wdata;
  logic [FW-1:0]    fill_rd_q;
  logic [FW-1:0]    fill_mem [NUM_BUCKETS];

  // Remainder unit picks the bucket
  bhs_mod_unit #(
    .DIVISOR (NUM_BUCKETS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (key_q),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  assign idx_inc = idx_q + 1'b1;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    key_d       = key_q;
    b_d         = b_q;
    base_d      = base_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    found_d     = found_q;
    rej_d       = rej_q;
    new_fill_d  = new_fill_q;
    mod_start   = 1'b0;
    out_load    = 1'b0;
    slot_we     = 1'b0;
    slot_waddr  = base_q + AW'(idx_q);
    slot_wdata  = slot_rd_q;
    slot_raddr  = base_q + AW'(idx_q);
    fill_we     = 1'b0;
    fill_waddr  = b_q;
    fill_wdata  = fill_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    case (state_q)
      ST_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_q;
        fill_wdata = '0;
        if (clr_q == BW'(NUM_BUCKETS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          key_d   = key_i;
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        // start the remainder on the cycle after capture
        mod_start = started_q;
        if (mod_done) begin
          b_d     = mod_rem;
          state_d = ST_FILL_REQ;
        end
      end
      ST_FILL_REQ: begin
        base_d  = AW'(b_q * SLOTS_PER_BUCKET);
        state_d = ST_FILL_WAIT;
      end
      ST_FILL_WAIT: begin
        fill_d  = fill_rd_q;
        idx_d   = '0;
        found_d = 1'b0;
        state_d = ST_SCAN_REQ;
      end
      ST_SCAN_REQ: begin
        if (idx_q >= fill_q) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (slot_rd_q == key_q) begin
          found_d = 1'b1;
          state_d = ST_DECIDE;
        end else begin
          idx_d   = idx_inc;
          state_d = ST_SCAN_REQ;
        end
      end
      ST_DECIDE: begin
        new_fill_d = fill_q;
        rej_d      = 1'b0;
        state_d    = ST_DONE;
        if (kind_q == KIND_INSERT) begin
          if (fill_q >= FW'(SLOTS_PER_BUCKET)) begin
            rej_d = 1'b1;
          end else if (!found_q) begin
            slot_we    = 1'b1;
            slot_waddr = base_q + AW'(fill_q);
            slot_wdata = key_q;
            fill_we    = 1'b1;
            fill_wdata = fill_q + 1'b1;
            new_fill_d = fill_q + 1'b1;
          end
        end else if (kind_q == KIND_DELETE && found_q) begin
          state_d = ST_SHIFT_REQ;
        end
      end
      ST_SHIFT_REQ: begin
        // pull the next entry down, or close the gap at the end
        slot_raddr = base_q + AW'(idx_inc);
        if (idx_inc >= fill_q) begin
          fill_we    = 1'b1;
          fill_wdata = fill_q - 1'b1;
          new_fill_d = fill_q - 1'b1;
          state_d    = ST_DONE;
        end else begin
          state_d = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        slot_we    = 1'b1;
        slot_waddr = base_q + AW'(idx_q);
        slot_wdata = slot_rd_q;
        idx_d      = idx_inc;
        state_d    = ST_SHIFT_REQ;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      started_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      started_q   <= (state_q == ST_IDLE) && in_valid_i;
    end
  end

  // Working registers and result register
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    key_q      <= key_d;
    b_q        <= b_d;
    base_q     <= base_d;
    fill_q     <= fill_d;
    idx_q      <= idx_d;
    found_q    <= found_d;
    rej_q      <= rej_d;
    new_fill_q <= new_fill_d;
    if (out_load) begin
      present_q  <= found_q;
      rejected_q <= rej_q;
      index_q    <= index_ext[INDEX_W-1:0];
      count_q    <= count_ext[COUNT_W-1:0];
    end
  end

  assign index_ext = {{INDEX_W{1'b0}}, b_q};
  assign count_ext = {{COUNT_W{1'b0}}, new_fill_q};

  // Slot memory: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  // Fill count memory, read at the current bucket
  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rd_q <= fill_mem[b_q];
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign present_o       = present_q;
  assign rejected_full_o = rejected_q;
  assign bucket_index_o  = index_q;
  assign bucket_count_o  = count_q;

endmodule

// ----- hdl/bhs_checker.sv -----
// ----------------------------------------------------------------------------
// Bucketed hash set checker
// Port-level checks on the hash set, bound to the top level.
// ----------------------------------------------------------------------------
`include "bucketed_hash_set_assert.svh"

module bhs_checker import bhs_pkg::*; #(
  parameter int NUM_BUCKETS      = 10,
  parameter int SLOTS_PER_BUCKET = 5
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               present_o,
  input logic               rejected_full_o,
  input logic [INDEX_W-1:0] bucket_index_o,
  input logic [COUNT_W-1:0] bucket_count_o
);

  // A stalled result holds its payload
  `BHS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable({present_o, rejected_full_o, bucket_index_o, bucket_count_o}),
    "result changed while stalled")

  // One transaction at a time: busy right after taking one
  `BHS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
    "input taken again before the previous transaction finished")

  // A refused insert reports a full bucket
  `BHS_ASSERT_NOW(a_reject_full, out_valid_o && rejected_full_o,
    bucket_count_o == COUNT_W'(SLOTS_PER_BUCKET),
    "refused insert with a bucket that is not full")

  // Bucket index stays below the bucket count where the field can show it
  `BHS_ASSERT_NOW(a_index_range, out_valid_o,
    (NUM_BUCKETS >= 16) || (32'(bucket_index_o) < NUM_BUCKETS),
    "bucket index out of range")

endmodule

bind bucketed_hash_set bhs_checker #(
  .NUM_BUCKETS      (NUM_BUCKETS),
  .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
) u_bhs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .present_o       (present_o),
  .rejected_full_o (rejected_full_o),
  .bucket_index_o  (bucket_index_o),
  .bucket_count_o  (bucket_count_o)
);
